// File: hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition implies a property in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hdl/sab_pkg.sv
package sab_pkg;
    localparam int SYM_W = 5;
    localparam int FLD_W = 13;

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b00000000001,
        ST_IDLE   = 11'b00000000010,
        ST_WALKRD = 11'b00000000100,
        ST_WALKCK = 11'b00000001000,
        ST_QLEN   = 11'b00000010000,
        ST_QLENCK = 11'b00000100000,
        ST_CPRD   = 11'b00001000000,
        ST_CPWR   = 11'b00010000000,
        ST_REDRD  = 11'b00100000000,
        ST_REDCK  = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;
endpackage

// File: hdl/suffix_automaton_builder.sv
// Suffix automaton builder: each accepted request returns one result (new last
// state, state count, its longest length, clone and full flags) and appends
// its symbol unless it is ignored or refused. State lives in two RAMs with
// registered reads: transitions (MAX_STATES*ALPHABET entries) and a per-state
// word holding {suffix link, longest length}. A request passes idle, a
// suffix-link walk that reads and checks each examined state, a length check
// when the walk stops on an existing transition, and, when a clone is made, a
// copy of all ALPHABET transitions and a redirect walk, then the result load.
// Ignored and refused symbols go from idle straight to the result load. The
// result sits in the output register, so the next request is taken while it
// waits; the block stalls only when a new result is ready and the old one is
// still unread. After reset the transition RAM is cleared one entry per cycle
// over all MAX_STATES*ALPHABET entries (212992 by default), during which no
// request is accepted. Symbols >= ALPHABET are ignored, and a symbol is refused
// with full_res when fewer than two free states remain.
`include "assert_macros.svh"

module suffix_automaton_builder #(
    parameter int MAX_STATES = 8192,
    parameter int ALPHABET   = 26
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [sab_pkg::SYM_W-1:0] s_symbol,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [sab_pkg::FLD_W-1:0] m_new_last_state,
    output logic [sab_pkg::FLD_W-1:0] m_state_count,
    output logic [sab_pkg::FLD_W-1:0] m_longest_length,
    output logic                      m_clone_made,
    output logic                      m_full_res
);
    import sab_pkg::*;

    localparam int SW    = $clog2(MAX_STATES);
    localparam int AW    = $clog2(ALPHABET);
    localparam int TD    = MAX_STATES * ALPHABET;
    localparam int TW    = $clog2(TD);
    localparam int CW    = (AW > SYM_W) ? AW : SYM_W;

    state_t          st_reg, st_next;
    logic [TW-1:0]   clr_reg;
    logic [SW-1:0]   last_reg, total_reg, cur_reg, pos_reg, q_reg, cl_reg;
    logic [SW-1:0]   lastlen_reg, curlen_reg, poslen_reg, qlen_reg, qlink_reg;
    logic [AW-1:0]   c_reg, k_reg;
    logic            clone_reg, full_reg;
    logic            ovf_c, sym_ok_c;

    // transition RAM
    logic          t_we;
    logic [TW-1:0] t_wa, t_ra;
    logic [SW-1:0] t_wd, t_rd;
    // node RAM: {suffix link, longest length}
    logic            n_we;
    logic [SW-1:0]   n_wa, n_ra;
    logic [2*SW-1:0] n_wd, n_rd;
    logic [SW-1:0]   rd_link, rd_len;

    sab_ram #(.WIDTH(SW), .DEPTH(TD)) u_trans (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    sab_ram #(.WIDTH(2*SW), .DEPTH(MAX_STATES)) u_node (
        .aclk(aclk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

    function automatic logic [TW-1:0] taddr(input logic [SW-1:0] s, input logic [AW-1:0] c);
        taddr = TW'(s) * TW'(ALPHABET) + TW'(c);
    endfunction

    assign rd_link  = n_rd[2*SW-1:SW];
    assign rd_len   = n_rd[SW-1:0];
    assign s_ready  = (st_reg == ST_IDLE);
    assign sym_ok_c = 32'(s_symbol) < 32'(ALPHABET);
    assign ovf_c    = (32'(total_reg) + 32'd2) > 32'(MAX_STATES - 1);

    always_comb begin
        st_next = st_reg;
        t_we = 1'b0; t_wa = taddr(pos_reg, c_reg); t_wd = cur_reg;
        t_ra = taddr(pos_reg, c_reg);
        n_we = 1'b0; n_wa = cur_reg; n_wd = {SW'(1), curlen_reg}; n_ra = pos_reg;
        case (st_reg)
            ST_CLEAR: begin
                // zero the transition table; root gets link 0, length 0
                t_we = 1'b1; t_wa = clr_reg; t_wd = '0;
                n_we = 1'b1; n_wa = SW'(1); n_wd = '0;
                if (clr_reg == TW'(TD - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    st_next = (sym_ok_c && !ovf_c) ? ST_WALKRD : ST_OUT;
                end
            end
            ST_WALKRD: begin
                st_next = ST_WALKCK;   // reads issued by defaults: trans, node of pos
            end
            ST_WALKCK: begin
                if (t_rd == '0) begin
                    t_we = 1'b1;
                    st_next = ST_WALKRD;
                    if (rd_link == '0) begin
                        // root has no transition either: new state links to root
                        n_we = 1'b1; n_wd = {SW'(1), curlen_reg};
                        st_next = ST_OUT;
                    end
                end else begin
                    st_next = ST_QLEN;
                end
            end
            ST_QLEN: begin
                n_ra = q_reg;
                st_next = ST_QLENCK;
            end
            ST_QLENCK: begin
                if (poslen_reg + SW'(1) == rd_len) begin
                    n_we = 1'b1; n_wd = {q_reg, curlen_reg};
                    st_next = ST_OUT;
                end else begin
                    st_next = ST_CPRD;
                end
            end
            ST_CPRD: begin
                // q now links to the clone (rewritten on each pass)
                t_ra = taddr(q_reg, k_reg);
                n_we = 1'b1; n_wa = q_reg; n_wd = {cl_reg, qlen_reg};
                st_next = ST_CPWR;
            end
            ST_CPWR: begin
                t_we = 1'b1; t_wa = taddr(cl_reg, k_reg); t_wd = t_rd;
                n_we = 1'b1; n_wa = cl_reg; n_wd = {qlink_reg, poslen_reg + SW'(1)};
                st_next = (k_reg == AW'(ALPHABET - 1)) ? ST_REDRD : ST_CPRD;
            end
            ST_REDRD: begin
                st_next = ST_REDCK;
            end
            ST_REDCK: begin
                n_wd = {cl_reg, curlen_reg};
                if (t_rd == q_reg) begin
                    t_we = 1'b1; t_wd = cl_reg;
                    if (rd_link == '0) begin
                        n_we = 1'b1;
                        st_next = ST_OUT;
                    end else begin
                        st_next = ST_REDRD;
                    end
                end else begin
                    n_we = 1'b1;
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLEAR; clr_reg <= '0;
            last_reg <= SW'(1); total_reg <= SW'(1); lastlen_reg <= '0;
            clone_reg <= 1'b0; full_reg <= 1'b0;
            m_valid <= 1'b0;
            m_new_last_state <= '0; m_state_count <= '0; m_longest_length <= '0;
            m_clone_made <= 1'b0; m_full_res <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR) clr_reg <= clr_reg + TW'(1);
            if (st_reg == ST_OUT && !m_valid) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        clone_reg <= 1'b0;
                        full_reg  <= sym_ok_c && ovf_c;
                        if (sym_ok_c && !ovf_c) begin
                            c_reg       <= AW'(CW'(s_symbol));
                            cur_reg     <= total_reg + SW'(1);
                            total_reg   <= total_reg + SW'(1);
                            last_reg    <= total_reg + SW'(1);
                            pos_reg     <= last_reg;
                            curlen_reg  <= lastlen_reg + SW'(1);
                            lastlen_reg <= lastlen_reg + SW'(1);
                        end
                    end
                end
                ST_WALKCK: begin
                    if (t_rd == '0) begin
                        pos_reg <= rd_link;
                    end else begin
                        q_reg      <= t_rd;
                        poslen_reg <= rd_len;
                    end
                end
                ST_QLENCK: begin
                    if (poslen_reg + SW'(1) != rd_len) begin
                        cl_reg    <= total_reg + SW'(1);
                        total_reg <= total_reg + SW'(1);
                        clone_reg <= 1'b1;
                        qlink_reg <= rd_link;
                        qlen_reg  <= rd_len;
                        k_reg     <= '0;
                    end
                end
                ST_CPWR: begin
                    k_reg <= k_reg + AW'(1);
                end
                ST_REDCK: begin
                    if (t_rd == q_reg) pos_reg <= rd_link;
                end
                ST_OUT: begin
                    if (!m_valid) begin
                        m_new_last_state <= FLD_W'(last_reg);
                        m_state_count    <= FLD_W'(total_reg);
                        m_longest_length <= FLD_W'(lastlen_reg);
                        m_clone_made     <= clone_reg;
                        m_full_res       <= full_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_one_hot, aclk, aresetn, $onehot(st_reg), "state not one-hot")
    `ASSERT_NEXT(a_leave_idle, aclk, aresetn, s_valid && s_ready, st_reg != ST_IDLE, "request not taken")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_new_last_state) && $stable(m_state_count) && $stable(m_longest_length) && $stable(m_clone_made) && $stable(m_full_res), "result changed while stalled")
endmodule

// File: hdl/sab_ram.sv
module sab_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
